// ----- hdl/bba_pkg.sv -----
// shared constants for the block bitmap allocator
package bba_pkg;

  // field widths
  localparam int unsigned ID_W       = 14;
  localparam int unsigned TOTAL_W    = 15;
  localparam int unsigned RESERVED_W = 14;
  localparam int unsigned STATUS_W   = 2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd1;

  localparam logic [TOTAL_W-1:0]    TOTAL_RST    = 15'd16384;
  localparam logic [RESERVED_W-1:0] RESERVED_RST = 14'd1;

  // request codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

// ----- hdl/block_bitmap_allocator.sv -----
// top level of the first-fit block bitmap allocator
//
// usage: one request word (op_i, block_id_i) on the input channel gives
// exactly one result word (alloc_id_o, status_o) on the output channel,
// both valid/ready. configuration (block count, reserved count) goes
// through the plain write port while the block is idle; the user must
// keep to that, the block itself does not enforce it.
// a free request reads the word that holds the block at the accepting
// edge, writes it back, then loads the output register.
// an allocate request reads the bitmap words one a cycle until a free
// block turns up or the last word is searched; out of range or no room
// at all is answered without reading the bitmap.
// one request at a time: the next is taken once the result word is
// loaded into the output register.
// after reset a clearing pass writes every bitmap word to zero, one word a
// cycle; no request is taken meanwhile, configuration writes are.
// the output register lets a new request in while a result waits; if the
// receiver stalls, a finished request waits in its last state until the
// output register is free.
// WORD_BITS must be a power of two.
module block_bitmap_allocator
  import bba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 16384,
  parameter int unsigned WORD_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [ID_W-1:0]       block_id_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ID_W-1:0]       alloc_id_o,
  output logic [STATUS_W-1:0]   status_o
);

  // sizes derived from the parameters
  localparam int unsigned NWORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned SW     = $clog2(WORD_BITS);
  localparam int unsigned MAXW   = $clog2(MAX_BLOCKS + 1);
  // block numbers: wide enough for any block count the register can hold
  localparam int unsigned BW     = (MAXW > TOTAL_W) ? MAXW : TOTAL_W;

  // states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FREE  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic [AW-1:0]         w_q, w_d;
  logic [SW-1:0]         lo_q, lo_d;
  logic [ID_W-1:0]       res_id_q, res_id_d;
  logic [STATUS_W-1:0]   res_st_q, res_st_d;
  logic                  out_valid_q;
  logic [ID_W-1:0]       out_id_q;
  logic [STATUS_W-1:0]   out_st_q;
  logic [TOTAL_W-1:0]    total_q;
  logic [RESERVED_W-1:0] reserved_q;

  // memory port signals
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [WORD_BITS-1:0] wdata;
  logic                 re;
  logic [AW-1:0]        raddr;
  logic [WORD_BITS-1:0] rdata;

  // scan results
  logic          hit;
  logic [SW-1:0] hit_idx;
  logic          hi_en;

  // effective bounds
  logic [BW-1:0] limit;
  logic [BW-1:0] start;
  logic [BW-1:0] last_blk;
  logic [BW-1:0] id_ext;
  logic [BW-1:0] hit_blk;
  logic [AW-1:0] last_w;
  logic          out_free;
  logic          accept;

  assign limit    = (BW'(total_q) > BW'(MAX_BLOCKS)) ? BW'(MAX_BLOCKS) : BW'(total_q);
  assign start    = (reserved_q == '0) ? BW'(1) : BW'(reserved_q);
  assign last_blk = limit - BW'(1);
  assign last_w   = last_blk[SW+AW-1:SW];
  assign id_ext   = BW'(block_id_i);
  assign hi_en    = (w_q == last_w);
  assign hit_blk  = (BW'(w_q) << SW) | BW'(hit_idx);

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  bba_ram #(
    .DEPTH (NWORDS),
    .AW    (AW),
    .DW    (WORD_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bba_word_scan #(
    .WB (WORD_BITS),
    .SW (SW)
  ) u_scan (
    .word_i  (rdata),
    .lo_i    (lo_q),
    .hi_i    (last_blk[SW-1:0]),
    .hi_en_i (hi_en),
    .hit_o   (hit),
    .idx_o   (hit_idx)
  );

  // sequencer: clearing pass, request decode, word scan, free write-back, result hand-off
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    w_d      = w_q;
    lo_d     = lo_q;
    res_id_d = res_id_q;
    res_st_d = res_st_q;
    we       = 1'b0;
    waddr    = w_q;
    wdata    = rdata;
    re       = 1'b0;
    raddr    = w_q;

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(NWORDS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          res_id_d = '0;
          res_st_d = ST_OK;
          if (op_i == OP_FREE) begin
            if (id_ext >= limit) begin
              res_st_d = ST_RANGE;
              state_d  = S_DONE;
            end else begin
              // fetch the word that holds the block
              re      = 1'b1;
              raddr   = id_ext[SW+AW-1:SW];
              w_d     = id_ext[SW+AW-1:SW];
              lo_d    = id_ext[SW-1:0];
              state_d = S_FREE;
            end
          end else begin
            if (start >= limit) begin
              res_st_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              // first word of the search, lower bits are reserved
              re      = 1'b1;
              raddr   = start[SW+AW-1:SW];
              w_d     = start[SW+AW-1:SW];
              lo_d    = start[SW-1:0];
              state_d = S_SCAN;
            end
          end
        end
      end

      S_FREE: begin
        we      = 1'b1;
        waddr   = w_q;
        wdata   = rdata & ~(WORD_BITS'(1) << lo_q);
        state_d = S_DONE;
      end

      S_SCAN: begin
        if (hit) begin
          we       = 1'b1;
          waddr    = w_q;
          wdata    = rdata | (WORD_BITS'(1) << hit_idx);
          res_id_d = hit_blk[ID_W-1:0];
          state_d  = S_DONE;
        end else if (hi_en) begin
          res_st_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          // next word, whole word in the window from here on
          re    = 1'b1;
          raddr = w_q + AW'(1);
          w_d   = w_q + AW'(1);
          lo_d  = '0;
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q      <= w_d;
    lo_q     <= lo_d;
    res_id_q <= res_id_d;
    res_st_q <= res_st_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_id_q <= res_id_q;
      out_st_q <= res_st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign alloc_id_o  = out_id_q;
  assign status_o    = out_st_q;

  // configuration registers, indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= TOTAL_RST;
      reserved_q <= RESERVED_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_TOTAL) begin
        total_q <= cfg_data_i[TOTAL_W-1:0];
      end else if (cfg_idx_i == CFG_RESERVED) begin
        reserved_q <= cfg_data_i[RESERVED_W-1:0];
      end
    end
  end

endmodule

// ----- hdl/bba_ram.sv -----
// single port write, single port read bitmap memory with registered read data
module bba_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- hdl/bba_word_scan.sv -----
// lowest free bit of one bitmap word inside a bit window
module bba_word_scan #(
  parameter int unsigned WB = 32,
  parameter int unsigned SW = 5
) (
  input  logic [WB-1:0] word_i,
  input  logic [SW-1:0] lo_i,
  input  logic [SW-1:0] hi_i,
  input  logic          hi_en_i,
  output logic          hit_o,
  output logic [SW-1:0] idx_o
);

  logic [WB-1:0] cand;

  // free bits between the lower bound and, on the last word, the upper bound
  always_comb begin
    for (int j = 0; j < WB; j++) begin
      cand[j] = !word_i[j] && (SW'(j) >= lo_i) && (!hi_en_i || (SW'(j) <= hi_i));
    end
  end

  always_comb begin
    idx_o = '0;
    for (int j = WB - 1; j >= 0; j--) begin
      if (cand[j]) begin
        idx_o = SW'(j);
      end
    end
  end

  assign hit_o = |cand;

endmodule

// ----- dv/bba_checker.sv -----
// checker for block_bitmap_allocator: watches the ports, predicts every result word, compares
`timescale 1ns / 1ps
module bba_checker
  import bba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 16384
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  op_i,
  input  logic [ID_W-1:0]       block_id_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [ID_W-1:0]       alloc_id_i,
  input  logic [STATUS_W-1:0]   status_i,
  output int unsigned           pending_o,
  output int                    fail_count_o
);

  typedef struct packed {
    logic [ID_W-1:0]     alloc_id;
    logic [STATUS_W-1:0] status;
  } answer_t;

  // own copy of the bitmap and the two registers
  bit [MAX_BLOCKS-1:0]   used_blk;
  logic [TOTAL_W-1:0]    total_reg;
  logic [RESERVED_W-1:0] reserved_reg;

  answer_t answer_q[$];
  answer_t want;
  int      n_fail = 0;

  assign fail_count_o = n_fail;

  task automatic flag_mismatch(input string msg);
    $display("%0t bba mismatch: %s", $time, msg);
    n_fail++;
  endtask

  // first fit from the reserved boundary, or clear one bit
  function automatic answer_t compute_answer(input logic op, input logic [ID_W-1:0] id);
    answer_t     a;
    int unsigned lim;
    int unsigned b;
    a.alloc_id = '0;
    a.status   = ST_OK;
    lim = (total_reg < MAX_BLOCKS) ? total_reg : MAX_BLOCKS;
    if (op == OP_FREE) begin
      if (id >= lim) a.status = ST_RANGE;
      else used_blk[id] = 1'b0;
      return a;
    end
    b = (reserved_reg == 0) ? 1 : reserved_reg;
    while (b < lim && used_blk[b]) b++;
    if (b < lim) begin
      used_blk[b] = 1'b1;
      a.alloc_id  = ID_W'(b);
    end else begin
      a.status = ST_FULL;
    end
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_blk     = '0;
      total_reg    = TOTAL_RST;
      reserved_reg = RESERVED_RST;
      answer_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TOTAL) total_reg = cfg_data_i[TOTAL_W-1:0];
        else if (cfg_idx_i == CFG_RESERVED) reserved_reg = cfg_data_i[RESERVED_W-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (answer_q.size() == 0) begin
          flag_mismatch($sformatf("result word (%0d, %0d) with nothing awaited",
                                  alloc_id_i, status_i));
        end else begin
          want = answer_q.pop_front();
          if (alloc_id_i !== want.alloc_id)
            flag_mismatch($sformatf("alloc_id %0d, awaited %0d", alloc_id_i, want.alloc_id));
          if (status_i !== want.status)
            flag_mismatch($sformatf("status %0d, awaited %0d", status_i, want.status));
        end
      end
      if (in_valid_i && in_ready_i) answer_q.push_back(compute_answer(op_i, block_id_i));
      pending_o <= answer_q.size();
    end
  end

endmodule

// ----- dv/tb_block_bitmap_allocator.sv -----
// testbench top for block_bitmap_allocator: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps
module tb_block_bitmap_allocator;
  import bba_pkg::*;

  // a word may legally sit unaccepted through the clearing pass plus a
  // full bitmap scan plus a receiver stall; this is several times that
  localparam int unsigned STALL_LIMIT = 5000;
  // quiet tail after the last result, longer than the slowest request
  localparam int unsigned TAIL_CYCLES = 600;
  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned PHASE_WORDS = 83;
  localparam int unsigned ID_MAX      = (1 << ID_W) - 1;
  localparam int unsigned DATA_MAX    = (1 << CFG_DATA_W) - 1;
  // blocks the bitmap holds at the default size
  localparam int unsigned BLOCK_SPAN  = 16384;
  // first register index past the list, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  op_i        = OP_ALLOC;
  logic [ID_W-1:0]       block_id_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [ID_W-1:0]       alloc_id_o;
  logic [STATUS_W-1:0]   status_o;

  int unsigned pending;
  int          fail_count;
  int unsigned idle_run = 0;

  // idling odds in percent, changed per stimulus phase
  int send_idle_pct = 23;
  int recv_idle_pct = 67;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  block_bitmap_allocator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .block_id_i  (block_id_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .alloc_id_o  (alloc_id_o),
    .status_o    (status_o)
  );

  bba_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .op_i         (op_i),
    .block_id_i   (block_id_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .alloc_id_i   (alloc_id_o),
    .status_i     (status_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // receiver side: ready drops at random, odds set by the running phase
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // cycles since anything last moved on either channel or the config port
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin : watchdog
    while (idle_run < STALL_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  // one request word; a gap before it is taken with the sender's idling odds.
  // valid is only lowered when a gap is taken, so back-to-back words keep it high
  task automatic send_req(input logic op, input logic [ID_W-1:0] id);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    block_id_i <= id;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // stop sending and wait until every awaited result word has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned tot, res, lim, reff, hi, id, alloc_pct;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed part ---
    // reset settings: 16384 blocks, block 0 reserved; the clearing pass holds these off
    send_req(OP_ALLOC, '1);          // id ignored on allocate, all ones
    send_req(OP_ALLOC, '0);
    send_req(OP_FREE, ID_W'(1));
    send_req(OP_ALLOC, '0);          // lowest free again
    send_req(OP_FREE, ID_W'(2));
    send_req(OP_FREE, ID_W'(2));     // already free
    send_req(OP_FREE, '0);           // reserved block, bit cleared but still counts as used
    send_req(OP_FREE, '1);           // last block, in range
    send_req(OP_ALLOC, '0);
    settle();

    // tiny disk, zero reserved count falls back to one
    write_reg(CFG_TOTAL, 5);
    write_reg(CFG_RESERVED, 0);
    repeat (3) send_req(OP_ALLOC, '0);
    send_req(OP_ALLOC, '0);          // disk full
    send_req(OP_FREE, ID_W'(5));     // at the block count, out of range
    send_req(OP_FREE, ID_W'(4));
    send_req(OP_ALLOC, '0);
    send_req(OP_FREE, '1);           // far out of range
    settle();

    // oversized block count is clamped; reserved count at its top
    write_reg(CFG_TOTAL, DATA_MAX);
    write_reg(CFG_RESERVED, ID_MAX);
    write_reg(CFG_SPARE, 0);         // indexes past the list change nothing
    write_reg(CFG_IDX_W'(CFG_SPARE + 1), DATA_MAX);
    send_req(OP_ALLOC, '0);          // only the last block is left
    send_req(OP_ALLOC, '0);          // nothing left
    send_req(OP_FREE, '1);
    settle();

    // reserved count covers every block, then an empty disk
    write_reg(CFG_TOTAL, 2);
    write_reg(CFG_RESERVED, 2);
    send_req(OP_ALLOC, '0);
    settle();
    write_reg(CFG_TOTAL, 0);
    send_req(OP_FREE, '0);
    send_req(OP_ALLOC, '0);

    // --- random part ---
    // each phase picks a disk shape and a mix of allocate and free, keeping the
    // bitmap from the phase before; small disks dominate so they fill and drain
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      if (p == RAND_PHASES / 3) begin
        send_idle_pct = 67;
        recv_idle_pct = 23;
      end else if (p == 2 * RAND_PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: tot = $urandom_range(2, 64);
        6, 7:             tot = $urandom_range(65, 2048);
        8:                tot = BLOCK_SPAN;
        default:          tot = $urandom_range(BLOCK_SPAN + 1, DATA_MAX);
      endcase
      lim = (tot < BLOCK_SPAN) ? tot : BLOCK_SPAN;
      case ($urandom_range(0, 9))
        0:       res = 0;
        1:       res = $urandom_range(0, ID_MAX);
        2:       res = $urandom_range((lim > 3) ? lim - 3 : 0, (lim > ID_MAX) ? ID_MAX : lim);
        default: res = $urandom_range(1, 4);
      endcase
      reff = (res == 0) ? 1 : res;
      write_reg(CFG_TOTAL, tot);
      write_reg(CFG_RESERVED, res);
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'(CFG_SPARE + $urandom_range(0, 1)), $urandom_range(0, DATA_MAX));
      alloc_pct = $urandom_range(30, 80);

      for (int k = 0; k < PHASE_WORDS; k++) begin
        if ($urandom_range(0, 99) < alloc_pct) begin
          send_req(OP_ALLOC, ID_W'($urandom_range(0, ID_MAX)));
        end else begin
          case ($urandom_range(0, 9))
            // near the allocation frontier, where used blocks live
            0, 1, 2, 3, 4: begin
              hi = reff + 64;
              if (hi >= lim) hi = lim - 1;
              id = $urandom_range(0, hi);
            end
            // anywhere in range, and just past it
            5, 6, 7: begin
              hi = lim + 2;
              if (hi > ID_MAX) hi = ID_MAX;
              id = $urandom_range(0, hi);
            end
            default: id = $urandom_range(0, ID_MAX);
          endcase
          send_req(OP_FREE, ID_W'(id));
        end
      end
    end

    settle();
    // any stray result word in the tail is caught by the checker
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
